>>> src/imu_uart_frame_handler_defines.svh
// Assertion macros shared by the frame handler RTL.
`ifndef IMU_UART_FRAME_HANDLER_DEFINES_SVH
`define IMU_UART_FRAME_HANDLER_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define UFH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define UFH_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define UFH_ASSERT(label, prop, msg)
`define UFH_ASSERT_NEVER(label, cond, msg)

`endif

`endif

>>> src/imu_ufh_pkg.sv
// Types, constants and helper functions of the IMU UART frame handler.
`default_nettype none

package imu_ufh_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int CMP_W        = 10;

  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] SYNC_ACK   = 8'hEE;
  localparam logic [7:0] SYNC_RESP  = 8'hBB;
  localparam logic [7:0] SYNC_REQ   = 8'hAA;
  localparam logic [7:0] DIR_READ   = 8'h01;
  localparam logic [7:0] DIR_WRITE  = 8'h00;
  localparam logic [7:0] WRITE_LEN  = 8'h01;
  localparam logic [7:0] RESP_LEN   = 8'd46;
  localparam logic [7:0] READ_LEN_RESET = 8'd46;

  localparam int VIDX_W = 5;
  localparam logic [VIDX_W-1:0] LAST_VIDX  = 5'd16;
  localparam logic [VIDX_W-1:0] TEMP_VIDX  = 5'd15;
  localparam logic [VIDX_W-1:0] CALIB_VIDX = 5'd16;
  localparam logic [ADDR_W-1:0] PAYLOAD_BASE = ADDR_W'(2);

  localparam logic [2:0] READ_LAST_POS  = 3'd3;
  localparam logic [2:0] WRITE_LAST_POS = 3'd4;

  localparam logic [1:0] SCALE_HUNDREDTH = 2'd0;
  localparam logic [1:0] SCALE_SIXTEENTH = 2'd1;
  localparam logic [1:0] SCALE_RAW       = 2'd2;

  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_VALUE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_ACK    = 2'd2,
    CMD_DECODE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [6:0] addr;
    logic [7:0] data;
  } cmd_entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         tx_byte;
    logic [7:0]         ack_status;
    logic [VIDX_W-1:0]  value_index;
    logic signed [15:0] value;
    logic [1:0]         scale;
    logic               last;
  } result_t;

  // Buffer address of the low byte of a sensor value.
  function automatic logic [ADDR_W-1:0] value_addr(input logic [VIDX_W-1:0] idx);
    logic [5:0] off;
    case (idx)
      5'd0:    off = 6'd0;
      5'd1:    off = 6'd2;
      5'd2:    off = 6'd4;
      5'd3:    off = 6'd12;
      5'd4:    off = 6'd14;
      5'd5:    off = 6'd16;
      5'd6:    off = 6'd18;
      5'd7:    off = 6'd20;
      5'd8:    off = 6'd22;
      5'd9:    off = 6'd32;
      5'd10:   off = 6'd34;
      5'd11:   off = 6'd36;
      5'd12:   off = 6'd38;
      5'd13:   off = 6'd40;
      5'd14:   off = 6'd42;
      5'd15:   off = 6'd44;
      default: off = 6'd45;
    endcase
    return ADDR_W'(off) + PAYLOAD_BASE;
  endfunction

  function automatic logic [1:0] value_scale(input logic [VIDX_W-1:0] idx);
    logic [1:0] s;
    if (idx <= 5'd2 || (idx >= 5'd9 && idx <= 5'd14)) begin
      s = SCALE_HUNDREDTH;
    end else if (idx <= 5'd8) begin
      s = SCALE_SIXTEENTH;
    end else begin
      s = SCALE_RAW;
    end
    return s;
  endfunction

  // Byte at a given position of a read or write request.
  function automatic logic [7:0] req_byte(input cmd_entry_t e, input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = SYNC_REQ;
      3'd1:    b = (e.cmd == CMD_READ) ? DIR_READ : DIR_WRITE;
      3'd2:    b = {1'b0, e.addr};
      3'd3:    b = (e.cmd == CMD_READ) ? e.data : WRITE_LEN;
      default: b = e.data;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> src/imu_ufh_queue.sv
// Small command queue between the frame handler's front and back parts.
`default_nettype none

`include "imu_uart_frame_handler_defines.svh"

module imu_ufh_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  imu_ufh_pkg::cmd_entry_t push_data,
  output logic                    full,
  input  logic                    pop,
  output imu_ufh_pkg::cmd_entry_t pop_data,
  output logic                    empty
);

  imu_ufh_pkg::cmd_entry_t entries [imu_ufh_pkg::QUEUE_DEPTH];
  logic [imu_ufh_pkg::QPTR_W-1:0] head;
  logic [imu_ufh_pkg::QPTR_W-1:0] tail;
  logic [imu_ufh_pkg::QCNT_W-1:0] count;

  assign full     = (count == imu_ufh_pkg::QCNT_W'(imu_ufh_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[head];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + imu_ufh_pkg::QPTR_W'(1);
      end
      if (pop) begin
        head <= head + imu_ufh_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + imu_ufh_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - imu_ufh_pkg::QCNT_W'(1);
      end
    end
  end

  `UFH_ASSERT_NEVER(a_no_overflow, push && full && !pop, "command queue overflow")
  `UFH_ASSERT_NEVER(a_no_underflow, pop && empty, "command queue underflow")

endmodule

`default_nettype wire

>>> src/imu_ufh_front.sv
// Front part: accepts items, deframes received bytes and queues commands.
`default_nettype none

`include "imu_uart_frame_handler_defines.svh"

module imu_ufh_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_op,
  input  logic [7:0]              in_rx,
  input  logic [6:0]              in_addr,
  input  logic [7:0]              in_wdata,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [7:0]              cfg_data,
  output logic                    q_push,
  output imu_ufh_pkg::cmd_entry_t q_data,
  input  logic                    q_full,
  output imu_ufh_pkg::buf_wr_t    buf_wr,
  input  logic                    decode_done
);

  logic [7:0]                    read_length;
  logic [imu_ufh_pkg::CNT_W-1:0] frame_count;
  logic [imu_ufh_pkg::CNT_W-1:0] frame_count_next;
  logic [7:0]                    first_byte;
  logic [7:0]                    first_byte_next;
  logic [7:0]                    len_byte;
  logic [7:0]                    len_byte_next;
  logic                          awaiting_data;
  logic                          awaiting_data_next;
  logic                          decode_busy;
  logic                          decode_busy_next;

  logic                          accept;
  logic [imu_ufh_pkg::CNT_W-1:0] cnt_inc;
  logic [7:0]                    first_cur;
  logic [7:0]                    len_cur;

  // While the back part reads a response out of the buffer, nothing new may land in it.
  assign in_ready  = !decode_busy && !q_full;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign cnt_inc   = frame_count + imu_ufh_pkg::CNT_W'(1);
  assign first_cur = (frame_count == '0) ? in_rx : first_byte;
  assign len_cur   = (frame_count == imu_ufh_pkg::CNT_W'(1)) ? in_rx : len_byte;

  always_comb begin
    q_push             = 1'b0;
    q_data             = '0;
    buf_wr             = '0;
    frame_count_next   = frame_count;
    first_byte_next    = first_byte;
    len_byte_next      = len_byte;
    awaiting_data_next = awaiting_data;
    decode_busy_next   = decode_busy;

    if (decode_done) begin
      decode_busy_next = 1'b0;
    end

    if (accept) begin
      case (in_op)
        imu_ufh_pkg::OP_RX: begin
          buf_wr.en        = 1'b1;
          buf_wr.addr      = frame_count[imu_ufh_pkg::ADDR_W-1:0];
          buf_wr.data      = in_rx;
          first_byte_next  = first_cur;
          len_byte_next    = len_cur;
          frame_count_next = cnt_inc;
          if (first_cur == imu_ufh_pkg::SYNC_ACK) begin
            if (cnt_inc >= imu_ufh_pkg::CNT_W'(2)) begin
              q_push             = 1'b1;
              q_data.cmd         = imu_ufh_pkg::CMD_ACK;
              q_data.data        = in_rx;
              awaiting_data_next = 1'b0;
              frame_count_next   = '0;
            end
          end else if (first_cur == imu_ufh_pkg::SYNC_RESP) begin
            if (cnt_inc >= imu_ufh_pkg::CNT_W'(2) &&
                imu_ufh_pkg::CMP_W'(cnt_inc) >=
                imu_ufh_pkg::CMP_W'(len_cur) + imu_ufh_pkg::CMP_W'(2)) begin
              if (awaiting_data && len_cur == imu_ufh_pkg::RESP_LEN) begin
                q_push           = 1'b1;
                q_data.cmd       = imu_ufh_pkg::CMD_DECODE;
                decode_busy_next = 1'b1;
              end
              frame_count_next = '0;
            end
          end else begin
            frame_count_next = '0;
          end
          if (frame_count_next == imu_ufh_pkg::CNT_W'(imu_ufh_pkg::BUFFER_DEPTH)) begin
            frame_count_next = '0;
          end
        end
        imu_ufh_pkg::OP_READ: begin
          q_push             = 1'b1;
          q_data.cmd         = imu_ufh_pkg::CMD_READ;
          q_data.addr        = in_addr;
          q_data.data        = read_length;
          awaiting_data_next = 1'b1;
        end
        imu_ufh_pkg::OP_WRITE: begin
          q_push      = 1'b1;
          q_data.cmd  = imu_ufh_pkg::CMD_WRITE;
          q_data.addr = in_addr;
          q_data.data = in_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_length   <= imu_ufh_pkg::READ_LEN_RESET;
      frame_count   <= '0;
      awaiting_data <= 1'b0;
      decode_busy   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        read_length <= cfg_data;
      end
      frame_count   <= frame_count_next;
      awaiting_data <= awaiting_data_next;
      decode_busy   <= decode_busy_next;
    end
  end

  always_ff @(posedge clk) begin
    first_byte <= first_byte_next;
    len_byte   <= len_byte_next;
  end

  `UFH_ASSERT(a_decode_needs_pending, $rose(decode_busy) |-> $past(awaiting_data), "decode without pending read")
  `UFH_ASSERT(a_partial_frame_synced, (frame_count != '0) |-> (first_byte == imu_ufh_pkg::SYNC_ACK || first_byte == imu_ufh_pkg::SYNC_RESP), "partial frame with bad first byte")

endmodule

`default_nettype wire

>>> src/imu_ufh_back.sv
// Back part: holds the frame buffer, sends requests and unpacks responses.
`default_nettype none

`include "imu_uart_frame_handler_defines.svh"

module imu_ufh_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  output logic                    q_pop,
  input  imu_ufh_pkg::cmd_entry_t q_data,
  input  imu_ufh_pkg::buf_wr_t    buf_wr,
  output logic                    decode_done,
  output logic                    out_valid,
  input  logic                    out_ready,
  output imu_ufh_pkg::result_t    out_res
);

  typedef enum logic [3:0] {
    B_IDLE     = 4'b0001,
    B_SEND     = 4'b0010,
    B_DEC_READ = 4'b0100,
    B_DEC_EMIT = 4'b1000
  } back_state_t;

  back_state_t                          state;
  back_state_t                          state_next;
  imu_ufh_pkg::cmd_entry_t              cur;
  imu_ufh_pkg::cmd_entry_t              cur_next;
  logic [2:0]                           pos;
  logic [2:0]                           pos_next;
  logic [imu_ufh_pkg::VIDX_W-1:0]       vidx;
  logic [imu_ufh_pkg::VIDX_W-1:0]       vidx_next;

  logic [7:0]                           frame_mem [imu_ufh_pkg::BUFFER_DEPTH];
  logic [imu_ufh_pkg::ADDR_W-1:0]       lo_addr;
  logic [imu_ufh_pkg::ADDR_W-1:0]       hi_addr;
  logic [7:0]                           rd_lo;
  logic [7:0]                           rd_hi;

  logic                                 out_free;
  logic                                 emit;
  imu_ufh_pkg::result_t                 emit_res;
  logic                                 send_last;

  // Single-byte values (temperature, calibration) read the same byte on both ports.
  assign lo_addr = imu_ufh_pkg::value_addr(vidx);
  assign hi_addr = (vidx == imu_ufh_pkg::TEMP_VIDX || vidx == imu_ufh_pkg::CALIB_VIDX) ?
                   lo_addr : lo_addr + imu_ufh_pkg::ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      frame_mem[buf_wr.addr] <= buf_wr.data;
    end
    rd_lo <= frame_mem[lo_addr];
    rd_hi <= frame_mem[hi_addr];
  end

  assign out_free  = !out_valid || out_ready;
  assign send_last = (cur.cmd == imu_ufh_pkg::CMD_ACK) ||
                     (cur.cmd == imu_ufh_pkg::CMD_READ && pos == imu_ufh_pkg::READ_LAST_POS) ||
                     (cur.cmd == imu_ufh_pkg::CMD_WRITE && pos == imu_ufh_pkg::WRITE_LAST_POS);
  assign q_pop     = (state == B_IDLE) && !q_empty;

  always_comb begin
    state_next  = state;
    cur_next    = cur;
    pos_next    = pos;
    vidx_next   = vidx;
    emit        = 1'b0;
    emit_res    = '0;
    decode_done = 1'b0;

    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          cur_next   = q_data;
          pos_next   = '0;
          vidx_next  = '0;
          state_next = (q_data.cmd == imu_ufh_pkg::CMD_DECODE) ? B_DEC_READ : B_SEND;
        end
      end
      B_SEND: begin
        if (out_free) begin
          emit = 1'b1;
          if (cur.cmd == imu_ufh_pkg::CMD_ACK) begin
            emit_res.kind       = imu_ufh_pkg::KIND_ACK;
            emit_res.ack_status = cur.data;
          end else begin
            emit_res.kind    = imu_ufh_pkg::KIND_TX;
            emit_res.tx_byte = imu_ufh_pkg::req_byte(cur, pos);
          end
          emit_res.last = send_last;
          if (send_last) begin
            state_next = B_IDLE;
          end else begin
            pos_next = pos + 3'd1;
          end
        end
      end
      B_DEC_READ: begin
        state_next = B_DEC_EMIT;
      end
      B_DEC_EMIT: begin
        if (out_free) begin
          emit                 = 1'b1;
          emit_res.kind        = imu_ufh_pkg::KIND_VALUE;
          emit_res.value_index = vidx;
          emit_res.scale       = imu_ufh_pkg::value_scale(vidx);
          if (vidx == imu_ufh_pkg::TEMP_VIDX) begin
            emit_res.value = {{8{rd_lo[7]}}, rd_lo};
          end else if (vidx == imu_ufh_pkg::CALIB_VIDX) begin
            emit_res.value = {8'h00, rd_lo};
          end else begin
            emit_res.value = {rd_hi, rd_lo};
          end
          emit_res.last = (vidx == imu_ufh_pkg::LAST_VIDX);
          if (vidx == imu_ufh_pkg::LAST_VIDX) begin
            decode_done = 1'b1;
            state_next  = B_IDLE;
          end else begin
            vidx_next  = vidx + imu_ufh_pkg::VIDX_W'(1);
            state_next = B_DEC_READ;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur  <= cur_next;
    pos  <= pos_next;
    vidx <= vidx_next;
    if (emit) begin
      out_res <= emit_res;
    end
  end

  `UFH_ASSERT(a_emit_after_read, (state == B_DEC_EMIT) |-> ($past(state) == B_DEC_READ || $past(state) == B_DEC_EMIT), "value emitted without buffer read")

endmodule

`default_nettype wire

>>> src/imu_uart_frame_handler.sv
// Top level of the IMU UART frame handler: request framing and response deframing.
`default_nettype none

// This block serves both directions of a byte-wide UART link to a register-mapped
// IMU. A slave-side transaction carries one item: op 1 sends a four-byte read
// request (0xAA, 0x01, address, read_length) and marks a read as pending, op 2
// sends a five-byte write request (0xAA, 0x00, address, 0x01, data), op 0 hands
// in one received byte, and op 3 is ignored. Received bytes are collected in a
// 64-byte frame buffer. A 0xEE frame yields one acknowledge result and clears
// the pending read; a 0xBB frame of length 46 that completes while a read is
// pending yields 17 raw sensor values, each with a scale code that tells
// software whether to divide by 100, by 16 or not at all. Any other first byte
// restarts the deframer, as does a partial frame that fills the buffer. Every
// output transaction is one result, and tlast marks the final result of an item.
// The front part accepts an item per cycle while the command queue has room and
// no decode is running, so bytes that produce no result go through at one per
// cycle. Each queued command passes through the idle state of the back part and
// then yields its results: a read request four bytes, a write request five and
// an acknowledge one. A decoded response fetches each value by a registered buffer
// read, and input is held off so the buffer is not overwritten while it is read.
// The read_length register may be written at any time the block is idle; it
// resets to 46. No clearing pass follows reset.
module imu_uart_frame_handler (
  input  logic        clk,
  input  logic        rst,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // rx_byte [7:0], reg_addr [14:8], write_data [22:15]
  input  logic [1:0]  s_tuser,   // op [1:0]
  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // tx_byte [7:0], ack_status [15:8], value_index [20:16],
                                 // value [36:21], scale [38:37]
  output logic [1:0]  m_tuser,   // kind [1:0]
  output logic        m_tlast,
  // Configuration write of read_length.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic                    q_push;
  imu_ufh_pkg::cmd_entry_t q_push_data;
  logic                    q_full;
  logic                    q_pop;
  imu_ufh_pkg::cmd_entry_t q_pop_data;
  logic                    q_empty;
  imu_ufh_pkg::buf_wr_t    buf_wr;
  logic                    decode_done;
  imu_ufh_pkg::result_t    out_res;

  // The front part deframes received bytes and turns each item into a command.
  imu_ufh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (s_tuser),
    .in_rx       (s_tdata[7:0]),
    .in_addr     (s_tdata[14:8]),
    .in_wdata    (s_tdata[22:15]),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_push      (q_push),
    .q_data      (q_push_data),
    .q_full      (q_full),
    .buf_wr      (buf_wr),
    .decode_done (decode_done)
  );

  // Commands wait here so that the front keeps taking bytes while results drain.
  imu_ufh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // The back part produces the result transactions through its output register.
  imu_ufh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_data      (q_pop_data),
    .buf_wr      (buf_wr),
    .decode_done (decode_done),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_res     (out_res)
  );

  // Pack the result fields, lowest field first, padded to whole bytes.
  assign m_tdata = {1'b0, out_res.scale, out_res.value, out_res.value_index,
                    out_res.ack_status, out_res.tx_byte};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule

`default_nettype wire
